// File: rtl/shsort_pkg.sv
// shared types and constants of the shell sort block
package shsort_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned DATA_W       = 32;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     empty_res;
    logic                     overflow;
  } out_t;

  // requests from the top level to the sort engine
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              start;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] rd_data;
  } sts_t;

endpackage

// File: rtl/shsort_engine.sv
// element store and shell sort sequencer sharing one compare unit
module shsort_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shsort_pkg::cmd_t   cmd_i,
  output shsort_pkg::sts_t   sts_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_HOLD  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [shsort_pkg::DATA_W-1:0] mem_q [shsort_pkg::MAX_ELEMENTS];
  logic [shsort_pkg::DATA_W-1:0] rd_data_q;

  logic [2:0]                    state_q, state_d;
  logic [shsort_pkg::CNT_W-1:0]  n_q, n_d;
  logic [shsort_pkg::ADDR_W-1:0] gap_q, gap_d;
  logic [shsort_pkg::CNT_W-1:0]  i_q, i_d;
  logic [shsort_pkg::CNT_W-1:0]  j_q, j_d;
  logic [shsort_pkg::DATA_W-1:0] held_q, held_d;

  logic                          mem_wr_en;
  logic [shsort_pkg::ADDR_W-1:0] mem_wr_addr;
  logic [shsort_pkg::DATA_W-1:0] mem_wr_data;
  logic                          mem_rd_en;
  logic [shsort_pkg::ADDR_W-1:0] mem_rd_addr;

  logic [shsort_pkg::CNT_W-1:0]  gap_ext;
  logic [shsort_pkg::CNT_W-1:0]  j_minus;
  logic [shsort_pkg::ADDR_W-1:0] gap_half;

  assign gap_ext  = {1'b0, gap_q};
  assign j_minus  = j_q - gap_ext;
  assign gap_half = {1'b0, gap_q[shsort_pkg::ADDR_W-1:1]};

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    gap_d       = gap_q;
    i_d         = i_q;
    j_d         = j_q;
    held_d      = held_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = j_q[shsort_pkg::ADDR_W-1:0];
    mem_wr_data = held_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = i_q[shsort_pkg::ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        mem_wr_en   = cmd_i.wr_en;
        mem_wr_addr = cmd_i.wr_addr;
        mem_wr_data = cmd_i.wr_data;
        mem_rd_en   = cmd_i.rd_en;
        mem_rd_addr = cmd_i.rd_addr;
        if (cmd_i.start) begin
          n_d     = cmd_i.n;
          gap_d   = cmd_i.n[shsort_pkg::CNT_W-1:1];
          i_d     = {1'b0, cmd_i.n[shsort_pkg::CNT_W-1:1]};
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (i_q >= n_q) begin
          // pass done, halve the gap
          if (gap_half == '0) begin
            state_d = S_IDLE;
          end else begin
            gap_d = gap_half;
            i_d   = {1'b0, gap_half};
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = i_q[shsort_pkg::ADDR_W-1:0];
          state_d     = S_HOLD;
        end
      end
      S_HOLD: begin
        held_d  = rd_data_q;
        j_d     = i_q;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (j_q >= gap_ext) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = j_minus[shsort_pkg::ADDR_W-1:0];
          state_d     = S_CMP;
        end else begin
          mem_wr_en = 1'b1;
          i_d       = i_q + shsort_pkg::CNT_ONE;
          state_d   = S_FETCH;
        end
      end
      S_CMP: begin
        mem_wr_en = 1'b1;
        if ($signed(rd_data_q) > $signed(held_q)) begin
          // shift the larger element up one gap
          mem_wr_data = rd_data_q;
          j_d         = j_minus;
          state_d     = S_PROBE;
        end else begin
          i_d     = i_q + shsort_pkg::CNT_ONE;
          state_d = S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    gap_q  <= gap_d;
    i_q    <= i_d;
    j_q    <= j_d;
    held_q <= held_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_q <= mem_q[mem_rd_addr];
    end
  end

  assign sts_o.busy    = (state_q != S_IDLE);
  assign sts_o.rd_data = rd_data_q;

endmodule

// File: rtl/shell_sort_halving_gaps_top.sv
// top level of the shell sort block: load, sort and readout control
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+--------------------------
// in      | input     | in_valid_i / in_stall_o | in_data_i  (shsort_pkg::in_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (shsort_pkg::out_t)
//
// a load request goes straight to the store's write port; a read request passes the
// store's registered read port and then the output register, which the read data
// enters once that register is free to take it.
// the request flagged last starts the sort; every gap pass and every shift step
// runs on the store's single port pair.
// reset clears counts and flags only; the store itself is never cleared.
// in_stall_o is high while sorting, while a read is in flight, and while a
// stalled result occupies the output register.
module shell_sort_halving_gaps_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  shsort_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shsort_pkg::out_t  out_data_o
);

  shsort_pkg::cmd_t cmd;
  shsort_pkg::sts_t sts;

  // set state
  logic [shsort_pkg::CNT_W-1:0] count_q, count_d;
  logic [shsort_pkg::CNT_W-1:0] rd_pos_q, rd_pos_d;
  logic                         ovf_q, ovf_d;
  logic                         closed_q, closed_d;

  // read in flight, waiting on the store's read data
  logic pend_q, pend_d;
  logic pend_final_q, pend_final_d;
  logic pend_ovf_q, pend_ovf_d;

  // output register
  logic             out_valid_q, out_valid_d;
  shsort_pkg::out_t out_q, out_d;

  logic                         accept;
  logic                         out_free;
  logic                         res_valid;
  shsort_pkg::out_t             res;
  logic [shsort_pkg::CNT_W-1:0] base_cnt;
  logic [shsort_pkg::CNT_W-1:0] rd_pos_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = sts.busy || pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign base_cnt   = closed_q ? '0 : count_q;
  assign rd_pos_inc = rd_pos_q + shsort_pkg::CNT_ONE;

  always_comb begin
    count_d      = count_q;
    rd_pos_d     = rd_pos_q;
    ovf_d        = ovf_q;
    closed_d     = closed_q;
    pend_d       = pend_q;
    pend_final_d = pend_final_q;
    pend_ovf_d   = pend_ovf_q;
    cmd          = '0;
    res_valid    = 1'b0;
    res          = '0;

    if (accept) begin
      if (in_data_i.mode == shsort_pkg::MODE_LOAD) begin
        // a load after a closed set opens a fresh one
        if (closed_q) begin
          rd_pos_d = '0;
          ovf_d    = 1'b0;
          closed_d = 1'b0;
        end
        if (base_cnt < shsort_pkg::MAX_COUNT) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = base_cnt[shsort_pkg::ADDR_W-1:0];
          cmd.wr_data = in_data_i.value;
          count_d     = base_cnt + shsort_pkg::CNT_ONE;
        end else begin
          // store full: drop the value and report it
          count_d      = base_cnt;
          ovf_d        = 1'b1;
          res_valid    = 1'b1;
          res.overflow = 1'b1;
        end
        if (in_data_i.last) begin
          cmd.start = 1'b1;
          cmd.n     = count_d;
          rd_pos_d  = '0;
          closed_d  = 1'b1;
        end
      end else begin
        if (!closed_q || rd_pos_q >= count_q) begin
          // set still open or fully read out
          res_valid     = 1'b1;
          res.empty_res = 1'b1;
          res.overflow  = ovf_q;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_addr  = rd_pos_q[shsort_pkg::ADDR_W-1:0];
          pend_d       = 1'b1;
          pend_final_d = (rd_pos_inc == count_q);
          pend_ovf_d   = ovf_q;
          rd_pos_d     = rd_pos_inc;
        end
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pend_q && out_free) begin
      out_d.sorted_value = sts.rd_data;
      out_d.final_res    = pend_final_q;
      out_d.empty_res    = 1'b0;
      out_d.overflow     = pend_ovf_q;
      out_valid_d        = 1'b1;
      pend_d             = 1'b0;
    end else if (res_valid) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_pos_q    <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_pos_q    <= rd_pos_d;
      ovf_q       <= ovf_d;
      closed_q    <= closed_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_final_q <= pend_final_d;
    pend_ovf_q   <= pend_ovf_d;
    out_q        <= out_d;
  end

  shsort_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_rd_pos_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pos_q <= count_q)
    else $error("read position beyond element count");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= shsort_pkg::MAX_COUNT)
    else $error("element count beyond capacity");

  a_pend_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_valid_q |=> out_valid_q && !pend_q)
    else $error("read data did not reach the output register");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> sts.busy)
    else $error("sort request did not start the engine");

  a_pend_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> closed_q)
    else $error("read in flight on an open set");
`endif

endmodule

// File: bench/tb_shell_sort_halving_gaps_top.sv
// self-checking bench for the shell sort block: load, sort and sorted readout
`timescale 1ns / 100ps

module tb_shell_sort_halving_gaps_top;

  // run shape
  localparam int unsigned RANDOM_REQUESTS = 180;
  localparam int unsigned QUIET_TAIL      = 60;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned BIG_SET_READS   = 16;

  localparam logic LD = shsort_pkg::MODE_LOAD;
  localparam logic RD = shsort_pkg::MODE_READ;

  localparam logic signed [shsort_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [shsort_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // one line of the directed script: the request plus an optional hand-written readout
  typedef struct packed {
    shsort_pkg::in_t  req;
    bit               typed;
    shsort_pkg::out_t readout;
  } script_line_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid  = 1'b0;
  logic             in_stall;
  shsort_pkg::in_t  in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  shsort_pkg::out_t out_data;

  // travels with each request so the scoreboard sees it at the same edge
  bit               req_typed   = 1'b0;
  shsort_pkg::out_t req_readout = '0;

  // shadow copy of the block's state
  logic signed [shsort_pkg::DATA_W-1:0] shadow_store [shsort_pkg::MAX_ELEMENTS];
  int unsigned shadow_count  = 0;
  int unsigned shadow_rd_pos = 0;
  bit          shadow_dropped = 1'b0;
  bit          shadow_closed  = 1'b0;

  shsort_pkg::out_t expected_readouts [$];
  int unsigned failures       = 0;
  int unsigned requests_sent  = 0;
  int unsigned requests_taken = 0;
  int unsigned readouts_seen  = 0;
  int unsigned overflow_seen_cnt = 0;
  int unsigned sets_sorted    = 0;
  int unsigned holds_done     = 0;
  bit          quiet          = 1'b0;
  bit          hold_req       = 1'b0;

  shell_sort_halving_gaps_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow of the block
  // ---------------------------------------------------------------------------

  // gapped insertion passes, gap halving from count/2 down to 1
  function automatic void shell_sort_shadow();
    int unsigned gap;
    int unsigned i;
    int unsigned j;
    logic signed [shsort_pkg::DATA_W-1:0] held;
    for (gap = shadow_count / 2; gap > 0; gap = gap / 2) begin
      for (i = gap; i < shadow_count; i++) begin
        held = shadow_store[i];
        j = i;
        // signed compare: both operands are declared signed
        while (j >= gap && shadow_store[j - gap] > held) begin
          shadow_store[j] = shadow_store[j - gap];
          j -= gap;
        end
        shadow_store[j] = held;
      end
    end
  endfunction

  // applies one accepted request, returns the readout it causes if any
  function automatic void shadow_sort_step(input shsort_pkg::in_t req, output bit has_res,
                                           output shsort_pkg::out_t res);
    has_res = 1'b0;
    res     = '0;
    if (req.mode == shsort_pkg::MODE_LOAD) begin
      // a load after a closed set opens a fresh one
      if (shadow_closed) begin
        shadow_count   = 0;
        shadow_rd_pos  = 0;
        shadow_dropped = 1'b0;
        shadow_closed  = 1'b0;
      end
      if (shadow_count < shsort_pkg::MAX_ELEMENTS) begin
        shadow_store[shadow_count] = req.value;
        shadow_count++;
      end else begin
        // store full: value dropped, flagged at once and sticky for the set
        shadow_dropped = 1'b1;
        has_res        = 1'b1;
        res.overflow   = 1'b1;
      end
      if (req.last) begin
        shell_sort_shadow();
        shadow_rd_pos = 0;
        shadow_closed = 1'b1;
        sets_sorted++;
      end
    end else begin
      has_res      = 1'b1;
      res.overflow = shadow_dropped;
      if (!shadow_closed || shadow_rd_pos >= shadow_count) begin
        // open set or nothing left to read
        res.empty_res = 1'b1;
      end else begin
        res.sorted_value = shadow_store[shadow_rd_pos];
        shadow_rd_pos++;
        res.final_res = (shadow_rd_pos == shadow_count);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: one process checks the output and then predicts the input,
  // so the order within an edge is fixed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    bit               has_res;
    shsort_pkg::out_t pred;
    shsort_pkg::out_t got;
    shsort_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_readouts.size() == 0) begin
          $error("readout with nothing expected: %p", got);
          failures++;
        end else begin
          want = expected_readouts.pop_front();
          readouts_seen++;
          if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   got.sorted_value);
            failures++;
          end
          if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
            failures++;
          end
          if (got.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
            failures++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        shadow_sort_step(in_data, has_res, pred);
        requests_taken++;
        if (has_res) begin
          if (pred.overflow && in_data.mode == shsort_pkg::MODE_LOAD) overflow_seen_cnt++;
          // hand-written rows override the shadow's readout
          expected_readouts.push_back(req_typed ? req_readout : pred);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold on request, none in the tail
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned burst;
    logic        stall_val;
    forever begin
      if (hold_req) begin
        // long hold-off so the block backs up and stalls its input
        hold_req  = 1'b0;
        stall_val = 1'b1;
        burst     = LONG_HOLD;
        holds_done++;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        stall_val = 1'b0;
        burst     = $urandom_range(1, 12);
      end else begin
        stall_val = 1'b1;
        burst     = $urandom_range(1, 7);
      end
      out_stall <= stall_val;
      repeat (burst) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------
  function automatic shsort_pkg::in_t make_request(logic mode,
                                                   logic signed [shsort_pkg::DATA_W-1:0] v,
                                                   logic last);
    return {mode, v, last};
  endfunction

  function automatic shsort_pkg::out_t mk_readout(logic signed [shsort_pkg::DATA_W-1:0] v,
                                                  logic fin, logic emp, logic ovf);
    return {v, fin, emp, ovf};
  endfunction

  function automatic script_line_t script_line(shsort_pkg::in_t req, bit typed,
                                               shsort_pkg::out_t readout);
    return {req, typed, readout};
  endfunction

  // mix of full-range values, small clustered values with many repeats, and extremes
  function automatic logic signed [shsort_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // offers one request and returns at the edge where it is taken
  task automatic send_request(shsort_pkg::in_t req, bit typed = 1'b0,
                              shsort_pkg::out_t readout = '0);
    in_valid    <= 1'b1;
    in_data     <= req;
    req_typed   <= typed;
    req_readout <= readout;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    requests_sent++;
  endtask

  // random idle burst between requests
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_read();
    send_request(make_request(RD, $urandom, 1'($urandom_range(0, 1))));
    sender_gap();
  endtask

  // one well-formed set with random content, sometimes broken up, kept within budget
  task automatic run_random_set(int unsigned forced_size, bit long_hold,
                                int unsigned budget);
    int unsigned set_size;
    int unsigned reads;
    int unsigned k;
    case ($urandom_range(0, 19))
      0:          set_size = $urandom_range(65, 256);
      1, 2, 3:    set_size = $urandom_range(17, 64);
      default:    set_size = $urandom_range(1, 16);
    endcase
    if (forced_size != 0) set_size = forced_size;
    if (2 * set_size + 2 > budget) set_size = (budget > 4) ? (budget - 2) / 2 : 1;
    // stray read against the previous set
    if ($urandom_range(0, 9) == 0) send_read();
    for (k = 0; k < set_size; k++) begin
      send_request(make_request(LD, pick_value(), k == set_size - 1));
      sender_gap();
      // read while the set is still open
      if (k != set_size - 1 && $urandom_range(0, 19) == 0) send_read();
    end
    // sometimes abandon the readout part way, otherwise read to the end or past it
    if (!long_hold && $urandom_range(0, 6) == 0) reads = $urandom_range(0, set_size - 1);
    else reads = set_size + $urandom_range(0, 2);
    if (long_hold) hold_req = 1'b1;
    for (k = 0; k < reads; k++) send_read();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_line_t script [25];
    int unsigned  k;
    int unsigned  random_start;
    int unsigned  set_idx;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, both modes, empty and open-set reads, set restarts
    script[0]  = script_line(make_request(RD, 0, 0), 1, mk_readout(0, 0, 1, 0));
    script[1]  = script_line(make_request(LD, VAL_MAX, 0), 0, '0);
    script[2]  = script_line(make_request(LD, VAL_MIN, 0), 0, '0);
    script[3]  = script_line(make_request(LD, 0, 0), 0, '0);
    script[4]  = script_line(make_request(LD, -1, 0), 0, '0);
    script[5]  = script_line(make_request(LD, 1, 1), 0, '0);
    script[6]  = script_line(make_request(RD, 0, 0), 1, mk_readout(VAL_MIN, 0, 0, 0));
    script[7]  = script_line(make_request(RD, 0, 0), 0, '0);
    script[8]  = script_line(make_request(RD, 0, 0), 0, '0);
    script[9]  = script_line(make_request(RD, 0, 0), 0, '0);
    script[10] = script_line(make_request(RD, 0, 0), 1, mk_readout(VAL_MAX, 1, 0, 0));
    script[11] = script_line(make_request(RD, 0, 0), 1, mk_readout(0, 0, 1, 0));
    // single-element set
    script[12] = script_line(make_request(LD, 5, 1), 0, '0);
    script[13] = script_line(make_request(RD, 0, 0), 1, mk_readout(5, 1, 0, 0));
    // read fields that only matter for loads are ignored
    script[14] = script_line(make_request(RD, -1, 1), 1, mk_readout(0, 0, 1, 0));
    // read while open, then duplicates
    script[15] = script_line(make_request(LD, 3, 0), 0, '0);
    script[16] = script_line(make_request(RD, 0, 0), 1, mk_readout(0, 0, 1, 0));
    script[17] = script_line(make_request(LD, -7, 0), 0, '0);
    script[18] = script_line(make_request(LD, 3, 1), 0, '0);
    script[19] = script_line(make_request(RD, 0, 0), 0, '0);
    // new load before the readout finished drops the rest of the old set
    script[20] = script_line(make_request(LD, 9, 0), 0, '0);
    script[21] = script_line(make_request(LD, 2, 1), 0, '0);
    script[22] = script_line(make_request(RD, 0, 0), 1, mk_readout(2, 0, 0, 0));
    script[23] = script_line(make_request(RD, 0, 0), 1, mk_readout(9, 1, 0, 0));
    script[24] = script_line(make_request(RD, 0, 0), 1, mk_readout(0, 0, 1, 0));

    foreach (script[i]) begin
      send_request(script[i].req, script[i].typed, script[i].readout);
      sender_gap();
    end

    // full store: two loads past capacity are dropped, the second one closes the set
    for (k = 0; k < shsort_pkg::MAX_ELEMENTS + 2; k++) begin
      send_request(make_request(LD, pick_value(), k == shsort_pkg::MAX_ELEMENTS + 1));
      sender_gap();
    end
    // the lowest values of the big set, the rest is dropped by the next load
    for (k = 0; k < BIG_SET_READS; k++) send_read();

    // sender holds back until every readout of the big set is in
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_readouts.size() != 0);

    // random sets; the first one rides through a long receiver hold
    random_start = requests_sent;
    set_idx      = 0;
    while (requests_sent < random_start + RANDOM_REQUESTS) begin
      if (requests_sent >= random_start + RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      if (set_idx == 0) begin
        run_random_set(16, 1'b1, random_start + RANDOM_REQUESTS - requests_sent);
      end else begin
        run_random_set(0, 1'b0, random_start + RANDOM_REQUESTS - requests_sent);
      end
      set_idx++;
    end

    // drain, then keep the clock running for anything stray
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_readouts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d sets sorted, %0d readouts checked",
             requests_taken, sets_sorted, readouts_seen);
    $display("full-store set dropped %0d loads, %0d long receiver hold(s)",
             overflow_seen_cnt, holds_done);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run including the full-store sort
  initial begin : watchdog
    #40_000_000;
    $display("timeout with %0d readouts outstanding", expected_readouts.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
